FILE: rtl/core/calorimeter_trigger_jet_ht_combiner_macros.svh
// Assertion macros for the jet and high-tower trigger combiner.
`ifndef CALORIMETER_TRIGGER_JET_HT_COMBINER_MACROS_SVH
`define CALORIMETER_TRIGGER_JET_HT_COMBINER_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define CTJH_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ctjh assertion failed");

// Next-cycle implication, disabled in reset.
`define CTJH_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ctjh assertion failed");

`endif

FILE: rtl/core/ctjh_pkg.sv
// Package: types, constants and register codes of the jet/HT trigger combiner.
`timescale 1ns / 1ps
package ctjh_pkg;

    localparam int WORD_W     = 16;
    localparam int NUM_WORDS  = 8;
    localparam int THR_W      = 8;
    localparam int SUM_W      = 6;
    localparam int HSUM_W     = SUM_W + 1;
    localparam int OUT_W      = 13;
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;

    localparam int SUM_LSB    = 6;
    localparam int BHT_LSB    = 12;
    localparam int HTTP_BIT   = 15;
    localparam int EID_LSB    = 12;
    localparam int EHT_LSB    = 14;
    localparam int ETP_LSB    = 2;

    localparam int IDX_ENDCAP_A = 6;
    localparam int IDX_ENDCAP_B = 7;

    localparam logic [1:0] REG_THR_LOW  = 2'd0;
    localparam logic [1:0] REG_THR_MID  = 2'd1;
    localparam logic [1:0] REG_THR_HIGH = 2'd2;
    localparam logic [1:0] REG_PAIR_SEL = 2'd3;

    localparam logic [1:0] ID_NONE  = 2'd0;
    localparam logic [1:0] ID_FIRST = 2'd1;
    localparam logic [1:0] ID_SECOND = 2'd2;
    localparam logic [1:0] ID_THIRD = 2'd3;

    localparam logic PAIR_BACK_TO_BACK = 1'b0;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [NUM_WORDS-1:0][WORD_W-1:0] t_words;

    typedef struct packed {
        logic [THR_W-1:0] thr_low;
        logic [THR_W-1:0] thr_mid;
        logic [THR_W-1:0] thr_high;
        logic             pair_sel;
    } t_cfg;

    function automatic logic [SUM_W-1:0] field_sum(input t_word w);
        field_sum = w[SUM_LSB +: SUM_W];
    endfunction

endpackage

FILE: rtl/core/ctjh_cfg_regs.sv
// APB-style configuration register file of the trigger combiner.
`timescale 1ns / 1ps
module ctjh_cfg_regs
    import ctjh_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    t_cfg       r_cfg;
    t_cfg       n_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[PADDR_W-1:2];

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_THR_LOW:  n_cfg.thr_low  = pwdata[THR_W-1:0];
                REG_THR_MID:  n_cfg.thr_mid  = pwdata[THR_W-1:0];
                REG_THR_HIGH: n_cfg.thr_high = pwdata[THR_W-1:0];
                REG_PAIR_SEL: n_cfg.pair_sel = pwdata[0];
                default:      n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_THR_LOW:  prdata = {{(PDATA_W-THR_W){1'b0}}, r_cfg.thr_low};
            REG_THR_MID:  prdata = {{(PDATA_W-THR_W){1'b0}}, r_cfg.thr_mid};
            REG_THR_HIGH: prdata = {{(PDATA_W-THR_W){1'b0}}, r_cfg.thr_high};
            REG_PAIR_SEL: prdata = {{(PDATA_W-1){1'b0}}, r_cfg.pair_sel};
            default:      prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/core/ctjh_combine.sv
// Combinational trigger logic: hybrid jet sums, thresholds, HT ORs, JP levels, HT.TP pairs.
`timescale 1ns / 1ps
module ctjh_combine
    import ctjh_pkg::*;
(
    input  t_words           i_words,
    input  t_cfg             i_cfg,
    output logic [OUT_W-1:0] o_trigger_word
);

    logic [HSUM_W-1:0] sum_a;
    logic [HSUM_W-1:0] sum_b;
    logic [2:0]        ht_b;
    logic [1:0]        ht_e;
    logic              jpb_ge1, jpb_ge2, jpb_ge3;
    logic              jpe_ge1, jpe_ge2, jpe_ge3;
    logic [2:0]        thr_hit;
    logic [1:0]        thr_cnt;
    logic [5:0]        hour;
    logic              b2b, nonadj, http;

    function automatic logic [HSUM_W-1:0] hybrid_sum(input t_word e, input t_word b0,
                                                     input t_word b1, input t_word b2);
        logic [SUM_W-1:0] add;
        case (e[EID_LSB +: 2])
            ID_FIRST:  add = field_sum(b0);
            ID_SECOND: add = field_sum(b1);
            ID_THIRD:  add = field_sum(b2);
            default:   add = '0;
        endcase
        hybrid_sum = {1'b0, field_sum(e)} + {1'b0, add};
    endfunction

    assign sum_a = hybrid_sum(i_words[IDX_ENDCAP_A], i_words[3], i_words[4], i_words[5]);
    assign sum_b = hybrid_sum(i_words[IDX_ENDCAP_B], i_words[0], i_words[1], i_words[2]);

    always_comb begin
        ht_b    = '0;
        jpb_ge1 = 1'b0;
        jpb_ge2 = 1'b0;
        jpb_ge3 = 1'b0;
        for (int i = 0; i < 6; i++) begin
            ht_b = ht_b | i_words[i][BHT_LSB +: 3];
            for (int j = 0; j < 3; j++) begin
                jpb_ge1 = jpb_ge1 | (|i_words[i][2*j +: 2]);
                jpb_ge2 = jpb_ge2 | i_words[i][2*j+1];
                jpb_ge3 = jpb_ge3 | (&i_words[i][2*j +: 2]);
            end
        end
    end

    assign ht_e    = i_words[IDX_ENDCAP_A][EHT_LSB +: 2] | i_words[IDX_ENDCAP_B][EHT_LSB +: 2];
    assign jpe_ge1 = (|i_words[IDX_ENDCAP_A][1:0]) | (|i_words[IDX_ENDCAP_B][1:0]);
    assign jpe_ge2 = i_words[IDX_ENDCAP_A][1] | i_words[IDX_ENDCAP_B][1];
    assign jpe_ge3 = (&i_words[IDX_ENDCAP_A][1:0]) | (&i_words[IDX_ENDCAP_B][1:0]);

    // hours ordered 4, 6, 8, 10, 12, 2 o'clock
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            hour[i]   = i_words[i+3][HTTP_BIT] | i_words[IDX_ENDCAP_A][ETP_LSB+i];
            hour[i+3] = i_words[i][HTTP_BIT]   | i_words[IDX_ENDCAP_B][ETP_LSB+i];
        end
    end

    assign b2b = (hour[0] & hour[3]) | (hour[1] & hour[4]) | (hour[2] & hour[5]);

    always_comb begin
        nonadj = 1'b0;
        for (int i = 0; i < 6; i++) begin
            for (int j = 0; j < 6; j++) begin
                if ((j - i >= 2) && (j - i <= 4)) begin
                    nonadj = nonadj | (hour[i] & hour[j]);
                end
            end
        end
    end

    assign http = (i_cfg.pair_sel == PAIR_BACK_TO_BACK) ? b2b : nonadj;

    assign thr_hit[0] = ({1'b0, sum_a} > i_cfg.thr_low)  || ({1'b0, sum_b} > i_cfg.thr_low);
    assign thr_hit[1] = ({1'b0, sum_a} > i_cfg.thr_mid)  || ({1'b0, sum_b} > i_cfg.thr_mid);
    assign thr_hit[2] = ({1'b0, sum_a} > i_cfg.thr_high) || ({1'b0, sum_b} > i_cfg.thr_high);
    assign thr_cnt    = {1'b0, thr_hit[0]} + {1'b0, thr_hit[1]} + {1'b0, thr_hit[2]};

    // max(count, jp_b, jp_e) > k iff any of them > k
    assign o_trigger_word[2:0]  = ht_b;
    assign o_trigger_word[3]    = http;
    assign o_trigger_word[5:4]  = ht_e;
    assign o_trigger_word[6]    = jpb_ge2;
    assign o_trigger_word[7]    = jpb_ge3;
    assign o_trigger_word[8]    = (|thr_cnt) | jpb_ge1 | jpe_ge1;
    assign o_trigger_word[9]    = thr_cnt[1] | jpb_ge2 | jpe_ge2;
    assign o_trigger_word[10]   = (&thr_cnt) | jpb_ge3 | jpe_ge3;
    assign o_trigger_word[11]   = jpe_ge2;
    assign o_trigger_word[12]   = jpe_ge3;

endmodule

FILE: rtl/core/calorimeter_trigger_jet_ht_combiner.sv
// Top level: input register, trigger logic and output register of the jet/HT combiner.
// One transfer per clock is sustained while i_stall stays low; each item passes from its
// input transfer through the input register and one combinational pass to the result
// register. A result held by i_stall does not block the input register, so one more
// item is taken before o_stall rises.
// Registers: 0x0 threshold low, 0x4 threshold mid, 0x8 threshold high (8 bits, strictly
// greater counts), 0xC pair select (0 back-to-back, 1 non-adjacent). All reset to 0.
`timescale 1ns / 1ps
`include "calorimeter_trigger_jet_ht_combiner_macros.svh"
module calorimeter_trigger_jet_ht_combiner
    import ctjh_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [WORD_W-1:0]  i_barrel_word_0,
    input  logic [WORD_W-1:0]  i_barrel_word_1,
    input  logic [WORD_W-1:0]  i_barrel_word_2,
    input  logic [WORD_W-1:0]  i_barrel_word_3,
    input  logic [WORD_W-1:0]  i_barrel_word_4,
    input  logic [WORD_W-1:0]  i_barrel_word_5,
    input  logic [WORD_W-1:0]  i_endcap_word_a,
    input  logic [WORD_W-1:0]  i_endcap_word_b,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [OUT_W-1:0]   o_trigger_word,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    t_cfg             cfg;
    t_words           r_words;
    logic             r_s1_valid;
    logic             n_s1_valid;
    logic             r_out_valid;
    logic [OUT_W-1:0] r_trig;
    logic [OUT_W-1:0] trig;
    logic             out_free;
    logic             s1_adv;
    logic             in_xfer;

    ctjh_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ctjh_combine u_comb (
        .i_words        (r_words),
        .i_cfg          (cfg),
        .o_trigger_word (trig)
    );

    assign out_free = !r_out_valid || !i_stall;
    assign s1_adv   = r_s1_valid && out_free;
    assign o_stall  = r_s1_valid && !out_free;
    assign in_xfer  = i_valid && !o_stall;

    always_comb begin
        if (in_xfer) begin
            n_s1_valid = 1'b1;
        end else if (s1_adv) begin
            n_s1_valid = 1'b0;
        end else begin
            n_s1_valid = r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_words <= {i_endcap_word_b, i_endcap_word_a, i_barrel_word_5, i_barrel_word_4,
                        i_barrel_word_3, i_barrel_word_2, i_barrel_word_1, i_barrel_word_0};
        end
        if (s1_adv) begin
            r_trig <= trig;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_trigger_word = r_trig;

    `CTJH_ASSERT_NEXT(a_in_lands, in_xfer, r_s1_valid)
    `CTJH_ASSERT_NEXT(a_s1_held, r_s1_valid && !s1_adv, r_s1_valid)
    `CTJH_ASSERT_NEXT(a_s1_to_out, s1_adv, o_valid)
    `CTJH_ASSERT_SAME(a_no_stall_empty, !r_out_valid || !r_s1_valid, !o_stall)

endmodule
